>>> rtl/core/ioirr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioirr_pkg
// Shared types and constants of the interrupt redirection register window.
// ----------------------------------------------------------------------------
package ioirr_pkg;

  // Bus offsets inside the window.
  localparam logic [7:0] SEL_OFFSET = 8'h00;
  localparam logic [7:0] WIN_OFFSET = 8'h10;

  // Register numbers reached through the data window.
  localparam logic [7:0] REG_ID    = 8'h00;
  localparam logic [7:0] REG_VER   = 8'h01;
  localparam logic [7:0] REG_ARB   = 8'h02;
  localparam logic [7:0] REG_TABLE = 8'h10;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Data constants.
  localparam logic [31:0] RO_LOW_BITS   = 32'h0000_5000;
  localparam logic [31:0] MASKED_RESET  = 32'h0001_0000;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
  localparam logic [31:0] VERSION_RESET = 32'h0017_0011;

  // A pin number taken from an 8-bit select value fits in seven bits.
  localparam int PIN_IDX_W   = 7;
  localparam int NUM_PINS_DEF = 24;

  // Table write command.
  typedef struct packed {
    logic                 low_we;
    logic                 dest_we;
    logic [PIN_IDX_W-1:0] pin;
    logic [31:0]          low_data;
    logic [7:0]           dest_data;
  } table_wr_t;

  // Register updates decided by one access.
  typedef struct packed {
    logic       sel_we;
    logic [7:0] sel_data;
    logic       id_we;
    logic [3:0] id_data;
    table_wr_t  tbl;
  } access_ctl_t;

endpackage

>>> rtl/core/ioirr_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioirr_table
// Redirection table: low words and destination bytes, with per-entry valid
// bits standing in for the reset values and a registered read port.
// ----------------------------------------------------------------------------
module ioirr_table #(
  parameter int NUM_PINS = ioirr_pkg::NUM_PINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ioirr_pkg::table_wr_t          wr,
  input  logic [ioirr_pkg::PIN_IDX_W-1:0] rd_pin,
  output logic [31:0]                   rd_low,
  output logic [7:0]                    rd_dest
);
  import ioirr_pkg::*;

  localparam int PIN_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  logic [31:0]         low_mem  [NUM_PINS];
  logic [7:0]          dest_mem [NUM_PINS];
  logic [NUM_PINS-1:0] low_vld_r;
  logic [NUM_PINS-1:0] dest_vld_r;

  logic             wr_ok;
  logic             rd_ok;
  logic [PIN_W-1:0] waddr;
  logic [PIN_W-1:0] raddr;
  logic             same_addr;

  logic [31:0] rd_low_r;
  logic [7:0]  rd_dest_r;
  logic        rd_low_vld_r;
  logic        rd_dest_vld_r;

  // Address checks; out-of-range pins never touch the arrays.
  assign wr_ok     = wr.pin < PIN_IDX_W'(NUM_PINS);
  assign rd_ok     = rd_pin < PIN_IDX_W'(NUM_PINS);
  assign waddr     = wr.pin[PIN_W-1:0];
  assign raddr     = rd_ok ? rd_pin[PIN_W-1:0] : '0;
  assign same_addr = wr_ok && rd_ok && (wr.pin == rd_pin);

  // Memory writes.
  always_ff @(posedge clk) begin
    if (wr.low_we && wr_ok) begin
      low_mem[waddr] <= wr.low_data;
    end
    if (wr.dest_we && wr_ok) begin
      dest_mem[waddr] <= wr.dest_data;
    end
  end

  // Valid bits mark entries written since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_vld_r  <= '0;
      dest_vld_r <= '0;
    end else begin
      if (wr.low_we && wr_ok) begin
        low_vld_r[waddr] <= 1'b1;
      end
      if (wr.dest_we && wr_ok) begin
        dest_vld_r[waddr] <= 1'b1;
      end
    end
  end

  // Registered read with write-first bypass, so the read data always
  // matches the entry after this cycle's write.
  always_ff @(posedge clk) begin
    if (wr.low_we && same_addr) begin
      rd_low_r <= wr.low_data;
    end else begin
      rd_low_r <= low_mem[raddr];
    end
    if (wr.dest_we && same_addr) begin
      rd_dest_r <= wr.dest_data;
    end else begin
      rd_dest_r <= dest_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_low_vld_r  <= 1'b0;
      rd_dest_vld_r <= 1'b0;
    end else begin
      rd_low_vld_r  <= (wr.low_we && same_addr) || low_vld_r[raddr];
      rd_dest_vld_r <= (wr.dest_we && same_addr) || dest_vld_r[raddr];
    end
  end

  // Entries never written read as their reset values.
  assign rd_low  = rd_low_vld_r ? rd_low_r : MASKED_RESET;
  assign rd_dest = rd_dest_vld_r ? rd_dest_r : 8'h00;

endmodule

>>> rtl/core/ioirr_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioirr_access
// Decode of one bus access: read value, error flag and register updates.
// ----------------------------------------------------------------------------
module ioirr_access #(
  parameter int NUM_PINS = ioirr_pkg::NUM_PINS_DEF
) (
  input  logic                   op,
  input  logic [7:0]             offset,
  input  logic [31:0]            write_data,
  input  logic [7:0]             select_r,
  input  logic [3:0]             unit_id_r,
  input  logic [31:0]            version_r,
  input  logic [31:0]            cur_low,
  input  logic [7:0]             cur_dest,
  output logic [31:0]            read_data,
  output logic                   access_error,
  output ioirr_pkg::access_ctl_t ctl
);
  import ioirr_pkg::*;

  logic [7:0]           idx;
  logic [PIN_IDX_W-1:0] pin;
  logic                 pin_ok;
  logic                 is_high;
  logic [31:0]          win_rd;
  logic                 win_err;

  // Pin number of a table select value.
  assign idx     = select_r - REG_TABLE;
  assign pin     = idx[7:1];
  assign is_high = idx[0];
  assign pin_ok  = (select_r >= REG_TABLE) && (pin < PIN_IDX_W'(NUM_PINS));

  // Window read of the selected register.
  always_comb begin
    win_rd  = ALL_ONES;
    win_err = 1'b0;
    case (select_r)
      REG_ID:  win_rd = {4'h0, unit_id_r, 24'h000000};
      REG_VER: win_rd = version_r;
      REG_ARB: win_rd = 32'h0;
      default: begin
        if (pin_ok) begin
          win_rd = is_high ? {cur_dest, 24'h000000} : cur_low;
        end else begin
          win_err = 1'b1;
        end
      end
    endcase
  end

  // Result and register updates.
  always_comb begin
    read_data         = 32'h0;
    access_error      = 1'b0;
    ctl.sel_we        = 1'b0;
    ctl.sel_data      = write_data[7:0];
    ctl.id_we         = 1'b0;
    ctl.id_data       = write_data[27:24];
    ctl.tbl.low_we    = 1'b0;
    ctl.tbl.dest_we   = 1'b0;
    ctl.tbl.pin       = pin;
    ctl.tbl.low_data  = (write_data & ~RO_LOW_BITS) | (cur_low & RO_LOW_BITS);
    ctl.tbl.dest_data = write_data[31:24];
    if (op == OP_WRITE) begin
      if (offset == SEL_OFFSET) begin
        ctl.sel_we = 1'b1;
      end else if (offset == WIN_OFFSET) begin
        // Version and arbitration registers ignore writes without error.
        access_error = win_err;
        if (select_r == REG_ID) begin
          ctl.id_we = 1'b1;
        end else if (pin_ok) begin
          ctl.tbl.low_we  = !is_high;
          ctl.tbl.dest_we = is_high;
        end
      end else begin
        access_error = 1'b1;
      end
    end else begin
      if (offset == SEL_OFFSET) begin
        read_data = {24'h0, select_r};
      end else if (offset == WIN_OFFSET) begin
        read_data    = win_rd;
        access_error = win_err;
      end else begin
        read_data    = ALL_ONES;
        access_error = 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/io_interrupt_redirect_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_interrupt_redirect_regs
// Indirect register window of an I/O interrupt controller.
// ----------------------------------------------------------------------------
// Each input beat is one bus access (tuser bit 0: 0 read, 1 write) at offset
// 0x00 (select) or 0x10 (data window); each produces exactly one result beat.
// A beat is registered at the input, decoded in one pass against the select,
// ID, version and redirection table state, and its result is registered in
// the output register when the output side can take it; one beat is taken
// every cycle while the output side keeps up. The table read port is
// registered and addressed from the next select value, so back-to-back select
// writes, table writes and reads see each other's effect. Table entries never
// written since reset read as masked low words and zero destinations.
// ----------------------------------------------------------------------------
module io_interrupt_redirect_regs #(
  parameter int NUM_PINS = ioirr_pkg::NUM_PINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] offset, [39:8] write_data
  input  logic [0:0]  in_tuser,   // [0] op
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_data
  output logic [0:0]  out_tuser,  // [0] access_error
  // Version register write.
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import ioirr_pkg::*;

  logic        s1_valid_r;
  logic        s1_op_r;
  logic [7:0]  s1_offset_r;
  logic [31:0] s1_wdata_r;

  logic        out_valid_r;
  logic [31:0] out_rdata_r;
  logic        out_err_r;

  logic [7:0]  select_r;
  logic [7:0]  select_nxt;
  logic [3:0]  unit_id_r;
  logic [31:0] version_r;

  logic        fire;
  logic [31:0] acc_rdata;
  logic        acc_err;
  access_ctl_t ctl;
  table_wr_t   tbl_wr;
  logic [7:0]  rd_idx;
  logic [31:0] cur_low;
  logic [7:0]  cur_dest;

  // Pipeline handshake.
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r     <= in_tuser[0];
      s1_offset_r <= in_tdata[7:0];
      s1_wdata_r  <= in_tdata[39:8];
    end
  end

  // Access decode.
  ioirr_access #(
    .NUM_PINS(NUM_PINS)
  ) u_access (
    .op          (s1_op_r),
    .offset      (s1_offset_r),
    .write_data  (s1_wdata_r),
    .select_r    (select_r),
    .unit_id_r   (unit_id_r),
    .version_r   (version_r),
    .cur_low     (cur_low),
    .cur_dest    (cur_dest),
    .read_data   (acc_rdata),
    .access_error(acc_err),
    .ctl         (ctl)
  );

  // Table writes only take effect when the beat moves on.
  always_comb begin
    tbl_wr         = ctl.tbl;
    tbl_wr.low_we  = ctl.tbl.low_we && fire;
    tbl_wr.dest_we = ctl.tbl.dest_we && fire;
  end

  // The table read follows the select value seen by the next beat.
  assign select_nxt = (fire && ctl.sel_we) ? ctl.sel_data : select_r;
  assign rd_idx     = select_nxt - REG_TABLE;

  ioirr_table #(
    .NUM_PINS(NUM_PINS)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (tbl_wr),
    .rd_pin (rd_idx[7:1]),
    .rd_low (cur_low),
    .rd_dest(cur_dest)
  );

  // Select, ID and version registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_r  <= 8'h00;
      unit_id_r <= 4'h0;
      version_r <= VERSION_RESET;
    end else begin
      select_r <= select_nxt;
      if (fire && ctl.id_we) begin
        unit_id_r <= ctl.id_data;
      end
      if (cfg_we) begin
        version_r <= cfg_wdata;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rdata_r <= acc_rdata;
      out_err_r   <= acc_err;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_rdata_r;
  assign out_tuser[0] = out_err_r;

endmodule
